/* hdl/chsi_pkg.sv */
`default_nettype none
package chsi_pkg;

  localparam int unsigned QW = 64;   // working width of every intermediate
  localparam int unsigned DW = 32;   // table and port data width

  typedef logic signed [QW-1:0] q_t;

  localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};
  localparam q_t ONE_Q = 64'sd65536;

  // register index codes
  localparam logic [2:0] REG_KNOT_COUNT = 3'd0;
  localparam logic [2:0] REG_START_SLOPE = 3'd1;
  localparam logic [2:0] REG_END_SLOPE = 3'd2;
  localparam logic [2:0] REG_START_AUTO = 3'd3;
  localparam logic [2:0] REG_END_AUTO = 3'd4;

  // saturating add in the 64-bit range
  function automatic q_t sadd(input q_t a, input q_t b);
    logic signed [QW:0] s;
    begin
      s = {a[QW-1], a} + {b[QW-1], b};
      if (s[QW] != s[QW-1]) sadd = s[QW] ? Q_MIN : Q_MAX;
      else sadd = s[QW-1:0];
    end
  endfunction

  // saturating negate
  function automatic q_t sneg(input q_t a);
    begin
      sneg = (a == Q_MIN) ? Q_MAX : -a;
    end
  endfunction

endpackage
`default_nettype wire

/* hdl/chsi_mul.sv */
`default_nettype none
// Q16.16 multiply of two 64-bit values, (a*b)/65536 truncated toward zero
// and saturated. Magnitudes are split into 32-bit halves; one 32x32
// partial product is formed per cycle and accumulated.
module chsi_mul (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire chsi_pkg::q_t          a,
  input  wire chsi_pkg::q_t          b,
  output logic                       done,
  output chsi_pkg::q_t               prod
);
  import chsi_pkg::*;

  typedef enum logic [1:0] {
    M_IDLE,
    M_RUN,
    M_FIN
  } mst_t;

  mst_t         st_r;
  logic [1:0]   step_r;
  logic [63:0]  ua_r, ub_r;
  logic         neg_r;
  logic [127:0] acc_r;
  logic [31:0]  op_a, op_b;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [111:0] shifted;
  logic [63:0]  lim;
  q_t           res;

  // select one partial product per step
  always_comb begin
    op_a = step_r[1] ? ua_r[63:32] : ua_r[31:0];
    op_b = step_r[0] ? ub_r[63:32] : ub_r[31:0];
    pp = {32'd0, op_a} * {32'd0, op_b};
    pp_sh = {64'd0, pp} << (7'd32 * ({6'd0, step_r[1]} + {6'd0, step_r[0]}));
  end

  always_comb begin
    shifted = acc_r[127:16];
    lim = neg_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (shifted[111:64] != '0 || shifted[63:0] > lim) res = neg_r ? Q_MIN : Q_MAX;
    else res = neg_r ? q_t'(-shifted[63:0]) : q_t'(shifted[63:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= M_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st_r)
        M_IDLE: begin
          if (start) begin
            ua_r <= a[63] ? 64'(-a) : 64'(a);
            ub_r <= b[63] ? 64'(-b) : 64'(b);
            neg_r <= a[63] ^ b[63];
            acc_r <= '0;
            step_r <= 2'd0;
            st_r <= M_RUN;
          end
        end
        M_RUN: begin
          acc_r <= acc_r + pp_sh;
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) st_r <= M_FIN;
        end
        M_FIN: begin
          prod <= res;
          done <= 1'b1;
          st_r <= M_IDLE;
        end
        default: st_r <= M_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hdl/chsi_div.sv */
`default_nettype none
// Signed 64-bit division n/d truncated toward zero, one quotient bit per
// cycle (restoring). A zero divisor returns zero.
module chsi_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire chsi_pkg::q_t          num,
  input  wire chsi_pkg::q_t          den,
  output logic                       done,
  output chsi_pkg::q_t               quo
);
  import chsi_pkg::*;

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [63:0] q_r, d_r;
  logic [64:0] rem_r;
  logic        neg_r, zero_r;
  logic [64:0] trial;
  logic [64:0] rsh;

  always_comb begin
    rsh = {rem_r[63:0], q_r[63]};
    trial = rsh - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          q_r <= num[63] ? 64'(-num) : 64'(num);
          d_r <= den[63] ? 64'(-den) : 64'(den);
          neg_r <= num[63] ^ den[63];
          zero_r <= (den == '0);
          rem_r <= '0;
          cnt_r <= '0;
          busy_r <= 1'b1;
        end
      end else begin
        // shift in one numerator bit, subtract when it fits
        if (!trial[64]) begin
          rem_r <= trial;
          q_r <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= rsh;
          q_r <= {q_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (zero_r) quo = '0;
    else quo = neg_r ? q_t'(-q_r) : q_t'(q_r);
  end
endmodule
`default_nettype wire

/* hdl/cubic_hermite_spline_interp.sv */
`default_nettype none
// Cubic Hermite spline interpolator, Q16.16.
// Input words on in_*: action 0 writes knot (position, sample_value) at
// knot_index into the knot tables and gives no result word; action 1 is a
// query that returns one word on out_* with the spline value, an
// out-of-range flag and a saturation flag.
// Registers on cfg_*: knot_count, start_slope, end_slope and the two auto-slope
// bits, to be written by the user only while the block is idle; the block does not enforce this.
// A load is written at its accept edge and the block stays ready, so loads
// can follow back to back. A query runs a bisection over the tables (one
// table read per step), up to five serial divisions (t and the four secants
// of two interior tangents) in one shared divider and eight multiplies in
// one shared multiplier.
// in_tready is low while a query is being worked on. The result is held in
// an output register until taken; new words are accepted meanwhile, and a
// query that finishes before the held result is taken waits for it.
// Reset clears control and sets the registers (knot_count to 4, the rest to zero);
// the knot tables are not cleared and must be loaded before use.
module cubic_hermite_spline_interp #(
  parameter int unsigned MAX_KNOTS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // {sample_value, position, knot_index}, lowest first
  input  wire logic [71:0] in_tdata,
  // action
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // {saturated, out_of_range, interpolated}, lowest first
  output logic [39:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import chsi_pkg::*;

  localparam int unsigned AW = $clog2(MAX_KNOTS);
  localparam int unsigned NW = AW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_RDW, S_CHK, S_BIS, S_SEL, S_SEC, S_SECW, S_T,
    S_MUL, S_POLY, S_TAN, S_ACC, S_OUT
  } st_t;

  // configuration
  logic [8:0]  knot_count_r;
  logic [31:0] start_slope_r, end_slope_r;
  logic        start_auto_r, end_auto_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r <= 9'd4;
      start_slope_r <= '0;
      end_slope_r <= '0;
      start_auto_r <= 1'b0;
      end_auto_r <= 1'b0;
    end else if (wr_en && cfg_paddr[1:0] == 2'b00) begin
      unique case (reg_idx)
        REG_KNOT_COUNT: knot_count_r <= cfg_pwdata[8:0];
        REG_START_SLOPE: start_slope_r <= cfg_pwdata;
        REG_END_SLOPE: end_slope_r <= cfg_pwdata;
        REG_START_AUTO: start_auto_r <= cfg_pwdata[0];
        REG_END_AUTO: end_auto_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      unique case (reg_idx)
        REG_KNOT_COUNT: cfg_prdata = {23'd0, knot_count_r};
        REG_START_SLOPE: cfg_prdata = start_slope_r;
        REG_END_SLOPE: cfg_prdata = end_slope_r;
        REG_START_AUTO: cfg_prdata = {31'd0, start_auto_r};
        REG_END_AUTO: cfg_prdata = {31'd0, end_auto_r};
        default: cfg_prdata = '0;
      endcase
    end
  end

  // knot tables: one write port, one registered read port
  logic [DW-1:0] x_mem [MAX_KNOTS];
  logic [DW-1:0] y_mem [MAX_KNOTS];
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rx_r, ry_r;
  logic          mem_we;
  logic [7:0]    in_idx;

  assign in_idx = in_tdata[7:0];
  assign mem_we = in_tvalid & in_tready & ~in_tuser &
                  ({24'd0, in_idx} < 32'(MAX_KNOTS));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      x_mem[AW'(in_idx)] <= in_tdata[39:8];
      y_mem[AW'(in_idx)] <= in_tdata[71:40];
    end
    rx_r <= x_mem[rd_addr];
    ry_r <= y_mem[rd_addr];
  end

  // shared units
  logic mul_start, mul_done, div_start, div_done;
  q_t   mul_a, mul_b, mul_p, div_n, div_d, div_q;

  chsi_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );
  chsi_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_n), .den(div_d),
    .done(div_done), .quo(div_q)
  );

  st_t           st_r;
  logic [NW-1:0] n_r, lo_r, hi_r, mid_r;
  q_t            x_r;
  logic [2:0]    rd_step_r, ret_r;
  // read slots: 0 x[lo] 1 x[hi] 2 x[0] 3 x[n-1] 4 x[mid]
  q_t            xlo_r, xhi_r, ylo_r, yhi_r, tmp_r;
  logic          oor_r;
  q_t            t_r, t2_r, t3_r, dx_r, h00_r, h10_r, h01_r, h11_r;
  q_t            mlo_r, mhi_r, acc_r;
  logic [3:0]    mstep_r;
  logic [1:0]    sstep_r;   // secant sub-step
  logic          send_r;    // 0: tangent at lo, 1: at hi
  logic [NW-1:0] si_r, sj_r;
  q_t            sx_r, sy_r, sec_a_r;
  logic          sec_second_r;
  logic          sec_avg_r;  // second secant of an interior tangent
  logic [39:0]   out_r;
  logic          out_v_r;
  logic [NW-1:0] n_clamp;
  q_t            rx_s, ry_s;

  assign rx_s = q_t'($signed(rx_r));
  assign ry_s = q_t'($signed(ry_r));

  always_comb begin
    if (knot_count_r < 9'd4) n_clamp = NW'(4);
    else if ({{(32-9){1'b0}}, knot_count_r} > 32'(MAX_KNOTS)) n_clamp = NW'(MAX_KNOTS);
    else n_clamp = NW'(knot_count_r);
  end

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;

  // read address mux and multiplier operands
  always_comb begin
    rd_addr = AW'(lo_r);
    unique case (st_r)
      S_RD: begin
        unique case (rd_step_r)
          3'd0: rd_addr = AW'(lo_r);
          3'd1: rd_addr = AW'(hi_r);
          3'd2: rd_addr = '0;
          3'd3: rd_addr = AW'(n_r - NW'(1));
          default: rd_addr = AW'(mid_r);
        endcase
      end
      S_SEC: rd_addr = sstep_r[0] ? AW'(sj_r) : AW'(si_r);
      default: rd_addr = AW'(lo_r);
    endcase
  end

  always_comb begin
    mul_a = t_r;
    mul_b = t_r;
    unique case (mstep_r)
      4'd0: begin mul_a = t_r; mul_b = t_r; end
      4'd1: begin mul_a = t2_r; mul_b = t_r; end
      4'd2: begin mul_a = h00_r; mul_b = ylo_r; end
      4'd3: begin mul_a = h10_r; mul_b = dx_r; end
      4'd4: begin mul_a = tmp_r; mul_b = mlo_r; end
      4'd5: begin mul_a = h01_r; mul_b = yhi_r; end
      4'd6: begin mul_a = h11_r; mul_b = dx_r; end
      default: begin mul_a = tmp_r; mul_b = mhi_r; end
    endcase
  end

  q_t t2x2, t3x2, t2x3;
  assign t2x2 = sadd(t2_r, t2_r);
  assign t3x2 = sadd(t3_r, t3_r);
  assign t2x3 = sadd(t2x2, t2_r);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_v_r <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (in_tvalid && in_tready && in_tuser) begin
            n_r <= n_clamp;
            x_r <= q_t'($signed(in_tdata[39:8]));
            lo_r <= NW'(1);
            hi_r <= n_clamp - NW'(2);
            oor_r <= 1'b0;
            rd_step_r <= 3'd0;
            ret_r <= 3'd0;
            st_r <= S_RD;
          end
        end
        // issue one table read, wait for registered data
        S_RD: st_r <= S_RDW;
        S_RDW: begin
          unique case (rd_step_r)
            3'd0: begin xlo_r <= rx_s; ylo_r <= ry_s; end
            3'd1: begin xhi_r <= rx_s; yhi_r <= ry_s; end
            default: tmp_r <= rx_s;
          endcase
          st_r <= (ret_r == 3'd0) ? S_CHK : (ret_r == 3'd1) ? S_BIS : S_SEL;
        end
        S_CHK: begin
          // read x[lo]=x1 then x[hi]
          if (rd_step_r == 3'd0) begin
            rd_step_r <= 3'd1;
            st_r <= S_RD;
          end else if (x_r > xlo_r && x_r <= xhi_r) begin
            ret_r <= 3'd1;
            st_r <= S_BIS;
            rd_step_r <= 3'd7;
          end else begin
            ret_r <= 3'd2;
            rd_step_r <= 3'd2;
            st_r <= S_RD;
          end
        end
        S_BIS: begin
          // x > x[lo] always holds inside the loop
          if (rd_step_r == 3'd4) begin
            if (x_r <= tmp_r) hi_r <= mid_r;
            else lo_r <= mid_r;
            rd_step_r <= 3'd7;
          end else if (hi_r - lo_r > NW'(1)) begin
            mid_r <= NW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
            rd_step_r <= 3'd4;
            st_r <= S_RD;
          end else begin
            // fetch final lo and hi entries
            ret_r <= 3'd3;
            rd_step_r <= 3'd0;
            st_r <= S_RD;
          end
        end
        S_SEL: begin
          unique case (rd_step_r)
            3'd2: begin
              if (x_r <= tmp_r) oor_r <= 1'b1;
              rd_step_r <= 3'd3;
              st_r <= S_RD;
            end
            3'd3: begin
              if (x_r > tmp_r) oor_r <= 1'b1;
              // x[1] is still in xlo_r
              if (x_r <= xlo_r) begin
                lo_r <= '0; hi_r <= NW'(1);
              end else begin
                lo_r <= n_r - NW'(2); hi_r <= n_r - NW'(1);
              end
              rd_step_r <= 3'd0;
              st_r <= S_RD;
            end
            3'd0: begin
              rd_step_r <= 3'd1;
              st_r <= S_RD;
            end
            default: begin
              // both ends loaded: start t division
              dx_r <= xhi_r - xlo_r;
              div_n <= (x_r - xlo_r) <<< 16;
              div_d <= xhi_r - xlo_r;
              div_start <= 1'b1;
              st_r <= S_T;
            end
          endcase
        end
        S_T: begin
          if (div_done) begin
            t_r <= div_q;
            mstep_r <= 4'd0;
            mul_start <= 1'b1;
            st_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            unique case (mstep_r)
              4'd0: begin
                t2_r <= mul_p; mstep_r <= 4'd1; mul_start <= 1'b1;
              end
              4'd1: begin
                t3_r <= mul_p; st_r <= S_POLY;
              end
              4'd2: begin
                acc_r <= mul_p; mstep_r <= 4'd3; mul_start <= 1'b1;
              end
              4'd3: begin
                tmp_r <= mul_p; send_r <= 1'b0; st_r <= S_TAN;
              end
              4'd4: begin
                acc_r <= sadd(acc_r, mul_p); mstep_r <= 4'd5; mul_start <= 1'b1;
              end
              4'd5: begin
                acc_r <= sadd(acc_r, mul_p); mstep_r <= 4'd6; mul_start <= 1'b1;
              end
              4'd6: begin
                tmp_r <= mul_p; send_r <= 1'b1; st_r <= S_TAN;
              end
              default: begin
                acc_r <= sadd(acc_r, mul_p); st_r <= S_ACC;
              end
            endcase
          end
        end
        S_POLY: begin
          h00_r <= sadd(sadd(t3x2, sneg(t2x3)), ONE_Q);
          h10_r <= sadd(sadd(t3_r, sneg(t2x2)), t_r);
          h01_r <= sadd(sneg(t3x2), t2x3);
          h11_r <= sadd(t3_r, sneg(t2_r));
          mstep_r <= 4'd2;
          mul_start <= 1'b1;
          st_r <= S_MUL;
        end
        // tangent at lo (send_r=0) or hi (send_r=1)
        S_TAN: begin
          logic [NW-1:0] k;
          k = send_r ? hi_r : lo_r;
          sec_second_r <= 1'b0;
          sec_avg_r <= 1'b0;
          if (k == '0) begin
            if (start_auto_r) begin
              si_r <= '0; sj_r <= NW'(1); sstep_r <= 2'd0; st_r <= S_SEC;
            end else begin
              mlo_r <= q_t'($signed(start_slope_r)); st_r <= S_ACC;
            end
          end else if (k == n_r - NW'(1)) begin
            if (end_auto_r) begin
              si_r <= n_r - NW'(2); sj_r <= k; sstep_r <= 2'd0; st_r <= S_SEC;
            end else begin
              mhi_r <= q_t'($signed(end_slope_r)); st_r <= S_ACC;
            end
          end else begin
            si_r <= k; sj_r <= k + NW'(1); sec_second_r <= 1'b1;
            sstep_r <= 2'd0; st_r <= S_SEC;
          end
        end
        S_SEC: st_r <= S_SECW;
        S_SECW: begin
          unique case (sstep_r)
            2'd0: begin
              sx_r <= rx_s; sy_r <= ry_s; sstep_r <= 2'd1; st_r <= S_SEC;
            end
            2'd1: begin
              div_n <= (ry_s - sy_r) <<< 16;
              div_d <= rx_s - sx_r;
              div_start <= 1'b1;
              sstep_r <= 2'd2;
            end
            default: begin
              if (div_done) begin
                if (sec_second_r) begin
                  // first secant of an interior tangent; now (k-1, k)
                  sec_a_r <= div_q;
                  sec_second_r <= 1'b0;
                  sec_avg_r <= 1'b1;
                  sj_r <= si_r;
                  si_r <= si_r - NW'(1);
                  sstep_r <= 2'd0;
                  st_r <= S_SEC;
                end else if (sec_avg_r) begin
                  // mean of both secants, truncated toward zero
                  if (send_r) mhi_r <= (sec_a_r + div_q) / 2;
                  else mlo_r <= (sec_a_r + div_q) / 2;
                  st_r <= S_ACC;
                end else begin
                  if (send_r) mhi_r <= div_q; else mlo_r <= div_q;
                  st_r <= S_ACC;
                end
              end
            end
          endcase
        end
        S_ACC: begin
          if (mstep_r == 4'd3) begin
            mstep_r <= 4'd4; mul_start <= 1'b1; st_r <= S_MUL;
          end else if (mstep_r == 4'd6) begin
            mstep_r <= 4'd7; mul_start <= 1'b1; st_r <= S_MUL;
          end else begin
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_v_r) begin
            if (acc_r > q_t'(64'sh7FFF_FFFF))
              out_r <= {6'd0, 1'b1, oor_r, 32'h7FFF_FFFF};
            else if (acc_r < q_t'(-64'sh8000_0000))
              out_r <= {6'd0, 1'b1, oor_r, 32'h8000_0000};
            else out_r <= {6'd0, 1'b0, oor_r, acc_r[31:0]};
            out_v_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
